// ----- rtl/accel_axis_to_decimal_display_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer decimal readout
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ACCEL_AXIS_TO_DECIMAL_DISPLAY_CORE_MACROS_SVH
`define ACCEL_AXIS_TO_DECIMAL_DISPLAY_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AXDD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AXDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/axdd_pkg.sv -----
// ----------------------------------------------------------------------------
// axdd_pkg
// Types and constants of the accelerometer decimal readout.
// ----------------------------------------------------------------------------
package axdd_pkg;

	localparam int DIGIT_COUNT = 5;
	localparam int DIGIT_W     = 4;
	localparam int CNT_W       = $clog2(DIGIT_COUNT);
	localparam int DIGITS_W    = DIGIT_COUNT * DIGIT_W;

	// Working value: holds the scaled product of the widest sample (< 2**21).
	localparam int VAL_W       = 21;
	localparam int QUO_W       = VAL_W - 3;

	// Division by ten as a multiplication by ceil(2**24 / 10); exact below 2**22.
	localparam int                RECIP_SHIFT = 24;
	localparam logic [VAL_W-1:0]  RECIP       = VAL_W'(1677722);
	localparam logic [QUO_W-1:0]  MAG_LIMIT   = QUO_W'(32767);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic FUNC_BUTTON = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIV,
		ST_DIGIT
	} state_t;

endpackage

// ----- rtl/accel_axis_to_decimal_display_core.sv -----
// ----------------------------------------------------------------------------
// accel_axis_to_decimal_display_core
// Axis-selectable accelerometer readout: scales the selected axis by 3.9 and
// gives a sign flag and five decimal digits of the saturated magnitude.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata: x_raw, y_raw, z_raw; tuser: func
// m_axis    out  tdata: negative, five digits; tuser: axis_shown
//
// A button transaction is taken and the input stays ready. A sample is
// scaled, then divided by ten and saturated, then its five digits are peeled
// off one at a time, all through one shared divide-by-ten unit; the input is
// not ready for the next sample until the result has been loaded. Reset
// clears the sequencer, the axis selector and the output valid. A stalled
// output holds the last digit step.
// ----------------------------------------------------------------------------
`include "accel_axis_to_decimal_display_core_macros.svh"

module accel_axis_to_decimal_display_core
	import axdd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // x_raw[15:0], y_raw[31:16], z_raw[47:32]
	input  logic [0:0]  s_axis_tuser,   // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // negative[0], units[4:1], tens[8:5],
	                                    // hundreds[12:9], thousands[16:13],
	                                    // ten_thousands[20:17], zero fill
	output logic [1:0]  m_axis_tuser    // axis_shown[1:0]
);

	localparam int PROD_W = SAMPLE_WIDTH + 5;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_COUNT - 1);

	state_t                    state_q, state_d;
	logic [1:0]                axis_q;
	logic [SAMPLE_WIDTH-1:0]   mag_q;
	logic                      neg_q;
	logic [1:0]                shown_q;
	logic [VAL_W-1:0]          val_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DIGITS_W-1:0]       digits_q;
	logic                      out_valid_q;
	logic [DIGITS_W:0]         out_data_q;
	logic [1:0]                out_axis_q;

	logic                      in_take;
	logic                      out_free;
	logic                      digit_step;
	logic                      out_load;
	logic [SAMPLE_WIDTH-1:0]   word;
	logic [PROD_W-1:0]         scaled;
	logic [2*VAL_W-1:0]        div_prod;
	logic [QUO_W-1:0]          div_q;
	logic [VAL_W-1:0]          div_tens;
	logic [VAL_W-1:0]          div_rem;
	logic [DIGITS_W-1:0]       digits_nx;

	// Input word of the selected axis; an unreachable selector reads as zero.
	always_comb begin
		unique case (axis_q)
			AXIS_X:  word = s_axis_tdata[SAMPLE_WIDTH-1:0];
			AXIS_Y:  word = s_axis_tdata[16 +: SAMPLE_WIDTH];
			AXIS_Z:  word = s_axis_tdata[32 +: SAMPLE_WIDTH];
			default: word = '0;
		endcase
	end

	// Times 39 as 32 + 4 + 2 + 1.
	assign scaled = (PROD_W'(mag_q) << 5) + (PROD_W'(mag_q) << 2)
		+ (PROD_W'(mag_q) << 1) + PROD_W'(mag_q);

	// Shared divide-by-ten unit: quotient by reciprocal, remainder by shift-add.
	assign div_prod  = val_q * RECIP;
	assign div_q     = div_prod[RECIP_SHIFT +: QUO_W];
	assign div_tens  = {div_q, 3'b000} + {2'b00, div_q, 1'b0};
	assign div_rem   = val_q - div_tens;
	assign digits_nx = {div_rem[DIGIT_W-1:0], digits_q[DIGITS_W-1:DIGIT_W]};

	assign out_free   = !out_valid_q || m_axis_tready;
	assign in_take    = s_axis_tvalid && s_axis_tready;
	assign digit_step = (state_q == ST_DIGIT) && ((cnt_q != CNT_LAST) || out_free);
	assign out_load   = digit_step && (cnt_q == CNT_LAST);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (s_axis_tuser[0] != FUNC_BUTTON)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_DIV;
			ST_DIV:   state_d = ST_DIGIT;
			ST_DIGIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take && (s_axis_tuser[0] == FUNC_BUTTON)) begin
				if ((axis_q == AXIS_Z) || (axis_q == 2'd3)) begin
					axis_q <= AXIS_X;
				end else begin
					axis_q <= axis_q + 2'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			shown_q <= axis_q;
			neg_q   <= word[SAMPLE_WIDTH-1];
			mag_q   <= word[SAMPLE_WIDTH-1] ? (~word + 1'b1) : word;
		end
		if (state_q == ST_SCALE) begin
			val_q <= VAL_W'(scaled);
		end
		if (state_q == ST_DIV) begin
			// Truncating divide, then saturate; a zero magnitude shows no sign.
			val_q <= VAL_W'((div_q > MAG_LIMIT) ? MAG_LIMIT : div_q);
			cnt_q <= '0;
			if (div_q == '0) begin
				neg_q <= 1'b0;
			end
		end
		if (digit_step) begin
			val_q    <= VAL_W'(div_q);
			digits_q <= digits_nx;
			cnt_q    <= cnt_q + 1'b1;
		end
		if (out_load) begin
			out_data_q <= {digits_nx, neg_q};
			out_axis_q <= shown_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_data_q};
	assign m_axis_tuser  = out_axis_q;

	`AXDD_ASSERT_NEXT(a_axis_wrap, in_take && (s_axis_tuser[0] == FUNC_BUTTON),
		axis_q == (($past(axis_q) == AXIS_Z) ? AXIS_X : $past(axis_q) + 2'd1),
		"button transaction did not advance the axis selector")
	`AXDD_ASSERT_SAME(a_digit_range, m_axis_tvalid,
		(m_axis_tdata[4:1] <= 4'd9) && (m_axis_tdata[8:5] <= 4'd9)
		&& (m_axis_tdata[12:9] <= 4'd9) && (m_axis_tdata[16:13] <= 4'd9)
		&& (m_axis_tdata[20:17] <= 4'd3),
		"result digit out of range")
	`AXDD_ASSERT_SAME(a_no_neg_zero, m_axis_tvalid && m_axis_tdata[0],
		m_axis_tdata[20:1] != 20'd0,
		"negative sign shown with a zero magnitude")

endmodule
